/* hw/rtl/ctts_pkg.sv */
// Shared types and constants for the character class table search core.
// Holds operation codes, controller states and the command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package ctts_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned CLASS_W = 16;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_RESP  = 4'b1000
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic probe;
    logic compare;
  } dp_cmd_t;

  typedef struct packed {
    logic early_miss;
    logic hit;
    logic range_done;
  } dp_sts_t;

endpackage

/* hw/rtl/char_type_table_search_core.sv */
// Character class table search core: appends sorted (code, class) pairs and
// looks codes up by binary search. Append, clear and an early miss go straight
// from idle to the result state; a lookup makes at most
// ceil(log2(TABLE_DEPTH + 1)) probes, each a registered memory read and then a
// compare. Busy stays high through the result state and falls as the controller
// returns to idle. Reset clears the fill count.
`timescale 1ns / 1ps

module char_type_table_search_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] char_code_i,
  input  logic [15:0] type_value_i,
  output logic        done_o,
  output logic [15:0] char_class_o,
  output logic        found_o,
  output logic        overflow_o
);

  ctts_pkg::dp_cmd_t cmd;
  ctts_pkg::dp_sts_t sts;

  ctts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ctts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .type_value_i (type_value_i),
    .sts_o        (sts),
    .char_class_o (char_class_o),
    .found_o      (found_o),
    .overflow_o   (overflow_o)
  );

endmodule

/* hw/rtl/ctts_ctrl.sv */
// Controller state machine for the character class table search core; uses ctts_pkg.
// Sequences each lookup that is not an early miss through probe and compare steps.
`timescale 1ns / 1ps

module ctts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        op_i,
  input  ctts_pkg::dp_sts_t sts_i,
  output ctts_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  ctts_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;

  assign busy_o = (state_q != ctts_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;
  assign done_o = (state_q == ctts_pkg::ST_RESP);

  assign cmd_o.accept  = accept;
  assign cmd_o.probe   = (state_q == ctts_pkg::ST_PROBE);
  assign cmd_o.compare = (state_q == ctts_pkg::ST_CMP);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctts_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i == ctts_pkg::OP_LOOKUP && !sts_i.early_miss) begin
            state_d = ctts_pkg::ST_PROBE;
          end else begin
            state_d = ctts_pkg::ST_RESP;
          end
        end
      end
      ctts_pkg::ST_PROBE: state_d = ctts_pkg::ST_CMP;
      ctts_pkg::ST_CMP: begin
        if (sts_i.hit || sts_i.range_done) begin
          state_d = ctts_pkg::ST_RESP;
        end else begin
          state_d = ctts_pkg::ST_PROBE;
        end
      end
      ctts_pkg::ST_RESP: state_d = ctts_pkg::ST_IDLE;
      default: state_d = ctts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/ctts_dp.sv */
// Datapath for the character class table search core: table memories,
// fill count, last code, search bounds and result registers; uses ctts_pkg.
`timescale 1ns / 1ps

module ctts_dp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctts_pkg::dp_cmd_t            cmd_i,
  input  logic [1:0]                   op_i,
  input  logic [ctts_pkg::CODE_W-1:0]  char_code_i,
  input  logic [ctts_pkg::CLASS_W-1:0] type_value_i,
  output ctts_pkg::dp_sts_t            sts_o,
  output logic [ctts_pkg::CLASS_W-1:0] char_class_o,
  output logic                         found_o,
  output logic                         overflow_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [ctts_pkg::CODE_W-1:0]  code_mem  [TABLE_DEPTH];
  logic [ctts_pkg::CLASS_W-1:0] class_mem [TABLE_DEPTH];

  logic [CW-1:0]                count_q;
  logic [ctts_pkg::CODE_W-1:0]  last_code_q;
  logic [ctts_pkg::CODE_W-1:0]  key_q;
  logic [CW-1:0]                lo_q, hi_q, mid_q;
  logic [ctts_pkg::CODE_W-1:0]  rd_code_q;
  logic [ctts_pkg::CLASS_W-1:0] rd_class_q;
  logic [ctts_pkg::CLASS_W-1:0] class_q;
  logic                         found_q;
  logic                         overflow_q;

  logic          full;
  logic          do_append;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW:0]   mid_inc;
  logic          key_lt;

  assign full      = (count_q == CW'(TABLE_DEPTH));
  assign do_append = cmd_i.accept && (op_i == ctts_pkg::OP_APPEND) && !full;

  // The upper bound is held exclusive, so the midpoint is (lo + hi - 1) / 2.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
  assign mid     = mid_sum[CW:1];
  assign mid_inc = {1'b0, mid_q} + (CW+1)'(1);
  assign key_lt  = (key_q < rd_code_q);

  assign sts_o.early_miss = (count_q == '0) || (char_code_i > last_code_q);
  assign sts_o.hit        = (key_q == rd_code_q);
  assign sts_o.range_done = key_lt ? (lo_q >= mid_q) : (mid_inc >= {1'b0, hi_q});

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      code_mem[count_q[AW-1:0]] <= char_code_i;
    end
    if (cmd_i.probe) begin
      rd_code_q <= code_mem[mid[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      class_mem[count_q[AW-1:0]] <= type_value_i;
    end
    if (cmd_i.probe) begin
      rd_class_q <= class_mem[mid[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_code_q <= '0;
    end else if (cmd_i.accept) begin
      if (op_i == ctts_pkg::OP_CLEAR) begin
        count_q     <= '0;
        last_code_q <= '0;
      end else if (do_append) begin
        count_q     <= count_q + CW'(1);
        last_code_q <= char_code_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q      <= char_code_i;
      lo_q       <= '0;
      hi_q       <= count_q;
      class_q    <= '0;
      found_q    <= 1'b0;
      overflow_q <= (op_i == ctts_pkg::OP_APPEND) && full;
    end else if (cmd_i.probe) begin
      mid_q <= mid;
    end else if (cmd_i.compare) begin
      if (sts_o.hit) begin
        class_q <= rd_class_q;
        found_q <= 1'b1;
      end else if (key_lt) begin
        hi_q <= mid_q;
      end else begin
        lo_q <= mid_inc[CW-1:0];
      end
    end
  end

  assign char_class_o = class_q;
  assign found_o      = found_q;
  assign overflow_o   = overflow_q;

endmodule
